[sv/mecanum_drive_mixer_top_defines.svh]
// ----------------------------------------------------------------------------
// mecanum drive mixer assertion macros
// shared property macros for the mixer checks
// ----------------------------------------------------------------------------
`ifndef MECANUM_DRIVE_MIXER_TOP_DEFINES_SVH
`define MECANUM_DRIVE_MIXER_TOP_DEFINES_SVH

// same-cycle implication under reset
`define MDM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define MDM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/mdm_pkg.sv]
// ----------------------------------------------------------------------------
// mecanum drive mixer package
// widths, register indexes, reset values and direction codes
// ----------------------------------------------------------------------------
package mdm_pkg;

  localparam int AXIS_W    = 16;
  localparam int THR_W     = 15;
  localparam int DIR_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 18;
  localparam int MAG_W     = 17;
  localparam int FAC_W     = 16;
  localparam int PROD_W    = MAG_W + FAC_W;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [THR_W-1:0]         thr_t;
  typedef logic [DIR_W-1:0]         dir_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t CFG_THR_MIN   = 2'd0;
  localparam cfg_idx_t CFG_THR_RANGE = 2'd1;

  localparam thr_t RST_THR_MIN   = 15'd4260;
  localparam thr_t RST_THR_RANGE = 15'd28508;

  localparam dir_t DIR_0   = 9'd0;
  localparam dir_t DIR_90  = 9'd90;
  localparam dir_t DIR_180 = 9'd180;
  localparam dir_t DIR_270 = 9'd270;

endpackage

[sv/mecanum_drive_mixer_top.sv]
// ----------------------------------------------------------------------------
// mecanum drive mixer
// mixes one joystick sample into four saturated Q1.15 wheel commands
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries strafe, forward, twist and throttle
//   axes plus the hat switch. a request is taken when in_valid is high and
//   in_stall is low; in_stall stays high while a sample is being mixed.
//   result channel out_valid/out_stall carries the four wheel commands, left
//   wheels already negated. config writes use cfg_valid/cfg_ready (always
//   ready) with cfg_index 0 = throttle minimum, 1 = throttle range.
// schedule:
//   one multiplier and one radix-4 restoring divider are shared by all four
//   wheels: setup states S_THR and S_THRADD, then per wheel a multiply, 8
//   divide steps and a saturate, then the output register is loaded. a
//   request with a valid direction gives one result, and the next request is
//   taken only once that result is loaded. a request whose stored hat
//   direction is not 0, 90, 180 or 270 gives no result and frees the input
//   after the S_THR state.
// reset and stall:
//   reset restores the default throttle registers, clears the stored hat
//   direction to 0 and drops out_valid. while out_stall holds a result, the
//   next request is still mixed but waits before its result is loaded.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mdm_pkg::axis_t    in_strafe_axis,
  input  mdm_pkg::axis_t    in_forward_axis,
  input  mdm_pkg::axis_t    in_twist_axis,
  input  mdm_pkg::axis_t    in_throttle_axis,
  input  logic              in_hat_pressed,
  input  mdm_pkg::dir_t     in_hat_angle,
  output logic              out_valid,
  input  logic              out_stall,
  output mdm_pkg::axis_t    out_front_right_drive,
  output mdm_pkg::axis_t    out_front_left_drive,
  output mdm_pkg::axis_t    out_back_right_drive,
  output mdm_pkg::axis_t    out_back_left_drive,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  mdm_pkg::cfg_idx_t cfg_index,
  input  mdm_pkg::thr_t     cfg_data
);
  import mdm_pkg::*;

`include "mecanum_drive_mixer_top_defines.svh"

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_THR    = 3'd1;
  localparam logic [2:0] S_THRADD = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_WB     = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic                    in_acc, out_load;
  logic                    out_valid_r;
  thr_t                    thr_min_r, thr_range_r;
  dir_t                    held_dir_r;
  axis_t                   x_r, y_r, t_r, a_r;
  logic signed [SUM_W-1:0] sum_r [4];
  logic signed [SUM_W-1:0] sum_nxt [4];
  logic [MAG_W-1:0]        scl_r;
  logic [FAC_W-1:0]        thr_r;
  logic [1:0]              idx_r;
  logic [2:0]              step_r;
  logic [MAG_W-1:0]        rem_r, rem_nxt;
  logic [FAC_W-1:0]        dvd_r, quo_r;
  logic [1:0]              qbits_nxt;
  axis_t                   wres_r [4];
  axis_t                   wres_nxt;
  axis_t                   fr_r, fl_r, br_r, bl_r;
  logic                    dir_ok;
  logic signed [SUM_W-1:0] xs, ys, ts, cur_sum;
  logic [MAG_W-1:0]        ax, ay, at, cur_mag, scl_nxt;
  logic [SUM_W-1:0]        mag_sum;
  logic signed [SUM_W-1:0] thr_lever;
  logic [MAG_W-1:0]        mul_a;
  logic [FAC_W-1:0]        mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic                    neg;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_front_right_drive = fr_r;
  assign out_front_left_drive  = fl_r;
  assign out_back_right_drive  = br_r;
  assign out_back_left_drive   = bl_r;

  // axis sums and scale
  always_comb begin
    xs = SUM_W'(x_r);
    ys = SUM_W'(y_r);
    ts = SUM_W'(t_r);
    ax = x_r[AXIS_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
    ay = y_r[AXIS_W-1] ? MAG_W'(-ys) : MAG_W'(ys);
    at = t_r[AXIS_W-1] ? MAG_W'(-ts) : MAG_W'(ts);
    mag_sum = SUM_W'(ax) + SUM_W'(ay) + SUM_W'(at);
    scl_nxt = (mag_sum < SUM_W'(32768)) ? MAG_W'(32768) : mag_sum[MAG_W-1:0];
    dir_ok = 1'b1;
    for (int i = 0; i < 4; i++) sum_nxt[i] = '0;
    unique case (held_dir_r)
      DIR_0: begin
        sum_nxt[0] = ys + xs + ts;  sum_nxt[1] = ys - xs - ts;
        sum_nxt[2] = ys - xs + ts;  sum_nxt[3] = ys + xs - ts;
      end
      DIR_90: begin
        sum_nxt[0] = -ys + xs + ts; sum_nxt[1] = ys + xs - ts;
        sum_nxt[2] = ys + xs + ts;  sum_nxt[3] = -ys + xs - ts;
      end
      DIR_180: begin
        sum_nxt[0] = -ys - xs + ts; sum_nxt[1] = -ys + xs - ts;
        sum_nxt[2] = -ys + xs + ts; sum_nxt[3] = -ys - xs - ts;
      end
      DIR_270: begin
        sum_nxt[0] = ys - xs + ts;  sum_nxt[1] = -ys - xs - ts;
        sum_nxt[2] = -ys - xs + ts; sum_nxt[3] = ys - xs - ts;
      end
      default: dir_ok = 1'b0;
    endcase
  end

  // shared multiplier
  always_comb begin
    thr_lever = SUM_W'(32768) - SUM_W'(a_r);
    cur_sum   = sum_r[idx_r];
    cur_mag   = cur_sum[SUM_W-1] ? MAG_W'(-cur_sum) : MAG_W'(cur_sum);
    if (state_r == S_THR) begin
      mul_a = thr_lever[MAG_W-1:0];
      mul_b = FAC_W'(thr_range_r);
    end else begin
      mul_a = cur_mag;
      mul_b = thr_r;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // shared divider, two quotient bits per step
  always_comb begin
    logic [MAG_W:0] trial;
    logic [MAG_W-1:0] rem_v;
    rem_v = rem_r;
    qbits_nxt = '0;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_v, dvd_r[FAC_W-1-k]};
      if (trial >= {1'b0, scl_r}) begin
        rem_v = MAG_W'(trial - {1'b0, scl_r});
        qbits_nxt[1-k] = 1'b1;
      end else begin
        rem_v = trial[MAG_W-1:0];
      end
    end
    rem_nxt = rem_v;
  end

  // sign, left-wheel flip and saturation
  always_comb begin
    neg = cur_sum[SUM_W-1] ^ idx_r[0];
    if (!neg) begin
      wres_nxt = (quo_r > FAC_W'(32767)) ? axis_t'(16'h7FFF) : axis_t'(quo_r);
    end else begin
      wres_nxt = (quo_r > FAC_W'(32768)) ? axis_t'(16'h8000) : axis_t'(-quo_r);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_THR;
      S_THR:    state_nxt = dir_ok ? S_THRADD : S_IDLE;
      S_THRADD: state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DIV;
      S_DIV:    if (step_r == 3'd7) state_nxt = S_WB;
      S_WB:     state_nxt = (idx_r == 2'd3) ? S_DONE : S_MUL;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_dir_r  <= DIR_0;
      thr_min_r   <= RST_THR_MIN;
      thr_range_r <= RST_THR_RANGE;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_hat_pressed) held_dir_r <= in_hat_angle;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THR_MIN:   thr_min_r   <= cfg_data;
          CFG_THR_RANGE: thr_range_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_strafe_axis;
      y_r <= in_forward_axis;
      t_r <= in_twist_axis;
      a_r <= in_throttle_axis;
    end
    case (state_r)
      S_THR: begin
        thr_r <= mul_p[31:16];
        scl_r <= scl_nxt;
        for (int i = 0; i < 4; i++) sum_r[i] <= sum_nxt[i];
      end
      S_THRADD: begin
        thr_r <= thr_r + FAC_W'(thr_min_r);
        idx_r <= '0;
      end
      S_MUL: begin
        rem_r  <= mul_p[PROD_W-1:FAC_W];
        dvd_r  <= mul_p[FAC_W-1:0];
        quo_r  <= '0;
        step_r <= '0;
      end
      S_DIV: begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[FAC_W-3:0], 2'b00};
        quo_r  <= {quo_r[FAC_W-3:0], qbits_nxt};
        step_r <= step_r + 3'd1;
      end
      S_WB: begin
        wres_r[idx_r] <= wres_nxt;
        idx_r         <= idx_r + 2'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      fr_r <= wres_r[0];
      fl_r <= wres_r[1];
      br_r <= wres_r[2];
      bl_r <= wres_r[3];
    end
  end

  `MDM_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_acc, state_r == S_THR, "accept did not start mixing")
  `MDM_ASSERT_NOW(a_rem_below_scale, clk, rst_n, state_r == S_DIV, rem_r < scl_r, "divider remainder not below scale")
  `MDM_ASSERT_NOW(a_quo_bounded, clk, rst_n, state_r == S_WB, quo_r <= thr_r, "wheel quotient exceeds throttle")
  `MDM_ASSERT_NOW(a_valid_from_done, clk, rst_n, out_valid_r && !$past(out_valid_r), $past(state_r) == S_DONE, "result shown without finishing")

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// mecanum drive mixer testbench
// drives joystick samples and throttle register writes into the mixer with
// random gaps and output stalls, predicts the four wheel commands in parallel
// and compares every result against the oldest pending prediction
// ----------------------------------------------------------------------------
module tb_top;
  import mdm_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASE_ITEMS   = 100;

  typedef struct {
    axis_t fr;
    axis_t fl;
    axis_t br;
    axis_t bl;
  } wheel_cmd_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  axis_t    in_strafe_axis;
  axis_t    in_forward_axis;
  axis_t    in_twist_axis;
  axis_t    in_throttle_axis;
  logic     in_hat_pressed;
  dir_t     in_hat_angle;
  logic     out_valid;
  logic     out_stall;
  axis_t    out_front_right_drive;
  axis_t    out_front_left_drive;
  axis_t    out_back_right_drive;
  axis_t    out_back_left_drive;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  thr_t     cfg_data;

  thr_t       model_thr_min;
  thr_t       model_thr_range;
  dir_t       model_dir;
  wheel_cmd_t pending_cmds[$];
  int         mismatch_count;
  int         quiet_cycles;
  bit         idle_on;

  mecanum_drive_mixer_top uut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic axis_t drive_level(longint sum, longint thr, longint scale, bit flip);
    longint v;
    v = (sum * thr) / scale;
    if (flip) begin
      v = -v;
    end
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return axis_t'(v);
  endfunction

  function automatic bit mix_sample(input axis_t xa, input axis_t ya, input axis_t ta,
                                    input axis_t aa, output wheel_cmd_t cmd);
    longint x, y, t, a, rng, mn, scale, thr;
    longint fr, fl, br, bl;
    x = xa;
    y = ya;
    t = ta;
    a = aa;
    rng = model_thr_range;
    mn = model_thr_min;
    scale = (x < 0 ? -x : x) + (y < 0 ? -y : y) + (t < 0 ? -t : t);
    if (scale < 32768) begin
      scale = 32768;
    end
    thr = ((32768 - a) * rng) / 65536 + mn;
    case (model_dir)
      DIR_0: begin
        fr = y + x + t;  fl = y - x - t;  br = y - x + t;  bl = y + x - t;
      end
      DIR_90: begin
        fr = -y + x + t; fl = y + x - t;  br = y + x + t;  bl = -y + x - t;
      end
      DIR_180: begin
        fr = -y - x + t; fl = -y + x - t; br = -y + x + t; bl = -y - x - t;
      end
      DIR_270: begin
        fr = y - x + t;  fl = -y - x - t; br = -y - x + t; bl = y - x - t;
      end
      default: begin
        return 1'b0;
      end
    endcase
    cmd.fr = drive_level(fr, thr, scale, 1'b0);
    cmd.fl = drive_level(fl, thr, scale, 1'b1);
    cmd.br = drive_level(br, thr, scale, 1'b0);
    cmd.bl = drive_level(bl, thr, scale, 1'b1);
    return 1'b1;
  endfunction

  task automatic check_drive(string name, axis_t exp, axis_t act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    wheel_cmd_t cmd;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THR_MIN:   model_thr_min = cfg_data;
          CFG_THR_RANGE: model_thr_range = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d %0d %0d %0d", $time,
                   out_front_right_drive, out_front_left_drive, out_back_right_drive,
                   out_back_left_drive);
          mismatch_count++;
        end else begin
          cmd = pending_cmds.pop_front();
          check_drive("front_right_drive", cmd.fr, out_front_right_drive);
          check_drive("front_left_drive", cmd.fl, out_front_left_drive);
          check_drive("back_right_drive", cmd.br, out_back_right_drive);
          check_drive("back_left_drive", cmd.bl, out_back_left_drive);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_hat_pressed) begin
          model_dir = in_hat_angle;
        end
        if (mix_sample(in_strafe_axis, in_forward_axis, in_twist_axis, in_throttle_axis,
                       cmd)) begin
          pending_cmds.push_back(cmd);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(axis_t x, axis_t y, axis_t t, axis_t a, logic pressed,
                             dir_t angle);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_strafe_axis   <= x;
    in_forward_axis  <= y;
    in_twist_axis    <= t;
    in_throttle_axis <= a;
    in_hat_pressed   <= pressed;
    in_hat_angle     <= angle;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, thr_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(thr_t thr_min, thr_t thr_range, bit junk);
    write_reg(CFG_THR_MIN, thr_min);
    write_reg(CFG_THR_RANGE, thr_range);
    if (junk) begin
      write_reg(cfg_idx_t'(2), thr_t'($urandom));
      write_reg(cfg_idx_t'(3), thr_t'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic axis_t rand_axis();
    case ($urandom_range(0, 5))
      0: return axis_t'(-32768);
      1: return axis_t'(32767);
      2, 3: return axis_t'(int'($urandom_range(0, 8000)) - 4000);
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic thr_t rand_thr(thr_t dflt);
    case ($urandom_range(0, 5))
      0: return thr_t'(0);
      1: return thr_t'(32767);
      2: return dflt;
      default: return thr_t'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic test_reset_defaults();
    idle_on = 1'b0;
    send_sample(0, 0, 0, 0, 1'b0, 9'h1FF);
    send_sample(32767, 0, 0, -32768, 1'b0, 0);
    send_sample(-32768, -32768, -32768, -32768, 1'b0, 0);
    send_sample(32767, 32767, 32767, 32767, 1'b0, 0);
    send_sample(100, -200, 300, 0, 1'b0, 0);
    send_sample(-32768, 32767, 0, 0, 1'b1, DIR_0);
  endtask

  task automatic test_directions();
    idle_on = 1'b1;
    send_sample(12000, -8000, 5000, -16384, 1'b1, DIR_90);
    send_sample(-3000, 20000, -7000, 8192, 1'b0, DIR_0);
    send_sample(12000, -8000, 5000, -16384, 1'b1, DIR_180);
    send_sample(-20000, -9000, 4000, -32768, 1'b1, DIR_270);
    send_sample(7000, 15000, -32768, 0, 1'b0, DIR_90);
    send_sample(12000, -8000, 5000, -16384, 1'b1, DIR_0);
  endtask

  task automatic test_bad_angle();
    idle_on = 1'b1;
    send_sample(5000, 5000, 5000, 0, 1'b1, 9'd45);
    send_sample(5000, 5000, 5000, 0, 1'b0, DIR_0);
    send_sample(-5000, 6000, 0, 0, 1'b1, 9'd359);
    send_sample(-5000, 6000, 0, 0, 1'b1, 9'h1FF);
    send_sample(-5000, 6000, 0, 0, 1'b1, DIR_90);
    wait_idle();
  endtask

  task automatic test_registers();
    idle_on = 1'b0;
    program_regs(0, 0, 1'b1);
    send_sample(32767, -32768, 1000, -32768, 1'b1, DIR_0);
    wait_idle();
    program_regs(32767, 32767, 1'b1);
    send_sample(32767, 0, 0, -32768, 1'b0, DIR_0);
    send_sample(-32768, 0, 0, -32768, 1'b0, DIR_0);
    send_sample(0, 0, 32767, 32767, 1'b1, DIR_270);
    wait_idle();
    program_regs(RST_THR_MIN, RST_THR_RANGE, 1'b0);
  endtask

  task automatic test_random();
    int r;
    dir_t angle;
    logic pressed;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        wait_idle();
        program_regs(rand_thr(RST_THR_MIN), rand_thr(RST_THR_RANGE),
                     1'($urandom_range(0, 1)));
      end
      if (i % 25 == 0) begin
        idle_on = ((i / 25) % 4 != 3);
      end
      r = $urandom_range(0, 99);
      angle = dir_t'($urandom);
      pressed = 1'b0;
      if (r < 25) begin
        pressed = 1'b1;
        case ($urandom_range(0, 3))
          0: angle = DIR_0;
          1: angle = DIR_90;
          2: angle = DIR_180;
          default: angle = DIR_270;
        endcase
      end else if (r < 30) begin
        pressed = 1'b1;
      end
      send_sample(rand_axis(), rand_axis(), rand_axis(), rand_axis(), pressed, angle);
    end
  endtask

  initial begin
    in_valid         <= 1'b0;
    in_strafe_axis   <= '0;
    in_forward_axis  <= '0;
    in_twist_axis    <= '0;
    in_throttle_axis <= '0;
    in_hat_pressed   <= 1'b0;
    in_hat_angle     <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_THR_MIN;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    idle_on          = 1'b0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    model_thr_min    = RST_THR_MIN;
    model_thr_range  = RST_THR_RANGE;
    model_dir        = DIR_0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directions();
    test_bad_angle();
    test_registers();
    test_random();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
